[design/dstp_pkg.sv]
// ----------------------------------------------------------------------------
// Decimal text parser package
// Item types, character codes, parse phases and saturation limits shared by
// the decimal scientific text parser.
// ----------------------------------------------------------------------------
package dstp_pkg;

    // Width of the digit accumulator and of the fraction and exponent counters.
    localparam int MANTISSA_WIDTH = 64;
    localparam int COUNT_WIDTH    = 14;
    localparam int EXP_WIDTH      = 16;

    localparam logic [63:0] ALL_NINES  = 64'd9999999999999999999;
    localparam logic [63:0] WIDTH_ONES = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - MANTISSA_WIDTH);
    localparam logic [MANTISSA_WIDTH-1:0] MANT_MAX =
        MANTISSA_WIDTH'((WIDTH_ONES < ALL_NINES) ? WIDTH_ONES : ALL_NINES);

    localparam int CNT_FIELD_MAX = (1 << COUNT_WIDTH) - 1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX =
        COUNT_WIDTH'((CNT_FIELD_MAX < 9999) ? CNT_FIELD_MAX : 9999);

    // ASCII codes.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LOW_E = 8'h65;
    localparam logic [7:0] CH_UP_E  = 8'h45;

    typedef enum logic [5:0] {
        PH_SKIP       = 6'b000001,
        PH_INT        = 6'b000010,
        PH_FRAC       = 6'b000100,
        PH_EXP_START  = 6'b001000,
        PH_EXP_DIGITS = 6'b010000,
        PH_DONE       = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } dstp_in_t;

    typedef struct packed {
        logic                        is_negative;
        logic [63:0]                 mantissa;
        logic signed [EXP_WIDTH-1:0] decimal_exponent;
        logic                        overflowed;
    } dstp_out_t;

endpackage

[design/decimal_scientific_text_parser_unit.sv]
// ----------------------------------------------------------------------------
// Decimal scientific text parser unit
// Parses one ASCII character per item into sign, digit mantissa and net
// decimal exponent; one result is given on the item marked end_of_text.
// ----------------------------------------------------------------------------
// Flow: an item is held in the input register and parsed there; the result
// of an item marked end_of_text is registered as that item leaves.
// Throughput: one item per cycle, but an end_of_text item waits for room in the
// result register; the loops are the digit and exponent multiply-by-ten adds.
// Reset: synchronous, active low; clears the parse state and both valid flags.
module decimal_scientific_text_parser_unit
    import dstp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  dstp_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output dstp_out_t m_data
);

    logic      in_valid_reg, in_valid_next;
    dstp_in_t  in_data_reg;
    logic      m_valid_reg, m_valid_next;
    dstp_out_t m_data_reg, m_data_next;

    phase_t                    phase_reg, phase_next, p_phase;
    logic                      neg_reg, neg_next, p_neg;
    logic [MANTISSA_WIDTH-1:0] acc_reg, acc_next, p_acc;
    logic [COUNT_WIDTH-1:0]    frac_reg, frac_next, p_frac;
    logic                      exp_neg_reg, exp_neg_next, p_exp_neg;
    logic [COUNT_WIDTH-1:0]    exp_reg, exp_next, p_exp;
    logic                      sat_reg, sat_next, p_sat;

    logic       fire;
    logic       out_free;
    logic [7:0] ch;
    logic [3:0] digit;
    logic       is_digit, is_space, is_sign, is_exp_mark, is_point;

    logic [MANTISSA_WIDTH+3:0] mant_step;
    logic                      mant_over;
    logic [COUNT_WIDTH+3:0]    exp_step;
    logic                      exp_over;
    logic                      frac_full;

    logic signed [EXP_WIDTH-1:0] exp_signed;

    // An item marked last needs room in the result register; others do not.
    assign out_free = !m_valid_reg || m_ready;
    assign fire     = in_valid_reg && (!in_data_reg.end_of_text || out_free);
    assign s_ready  = !in_valid_reg || fire;

    assign ch          = in_data_reg.char_code;
    assign digit       = 4'(ch - CH_ZERO);
    assign is_digit    = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_space    = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    assign is_sign     = (ch == CH_PLUS) || (ch == CH_MINUS);
    assign is_exp_mark = (ch == CH_LOW_E) || (ch == CH_UP_E);
    assign is_point    = (ch == CH_POINT);

    // acc * 10 + digit, kept four bits wider so the overflow shows.
    assign mant_step = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                     + (MANTISSA_WIDTH+4)'(digit);
    assign mant_over = mant_step > {4'b0, MANT_MAX};
    assign exp_step  = ({4'b0, exp_reg} << 3) + ({4'b0, exp_reg} << 1)
                     + (COUNT_WIDTH+4)'(digit);
    assign exp_over  = exp_step > {4'b0, COUNT_MAX};
    assign frac_full = frac_reg >= COUNT_MAX;

    always_comb begin
        p_phase   = phase_reg;
        p_neg     = neg_reg;
        p_acc     = acc_reg;
        p_frac    = frac_reg;
        p_exp_neg = exp_neg_reg;
        p_exp     = exp_reg;
        p_sat     = sat_reg;

        unique case (phase_reg)
            PH_SKIP: begin
                if (is_space) begin
                    p_phase = PH_SKIP;
                end else if (is_sign) begin
                    p_neg   = (ch == CH_MINUS);
                    p_phase = PH_INT;
                end else if (is_digit) begin
                    p_acc   = mant_over ? MANT_MAX : mant_step[MANTISSA_WIDTH-1:0];
                    p_sat   = sat_reg | mant_over;
                    p_phase = PH_INT;
                end else if (is_point) begin
                    p_phase = PH_FRAC;
                end else if (is_exp_mark) begin
                    p_phase = PH_EXP_START;
                end else begin
                    p_phase = PH_DONE;
                end
            end
            PH_INT: begin
                if (is_digit) begin
                    p_acc = mant_over ? MANT_MAX : mant_step[MANTISSA_WIDTH-1:0];
                    p_sat = sat_reg | mant_over;
                end else if (is_point) begin
                    p_phase = PH_FRAC;
                end else if (is_exp_mark) begin
                    p_phase = PH_EXP_START;
                end else begin
                    p_phase = PH_DONE;
                end
            end
            PH_FRAC: begin
                if (is_digit) begin
                    p_acc  = mant_over ? MANT_MAX : mant_step[MANTISSA_WIDTH-1:0];
                    p_frac = frac_full ? COUNT_MAX : frac_reg + 1'b1;
                    p_sat  = sat_reg | mant_over | frac_full;
                end else if (is_exp_mark) begin
                    p_phase = PH_EXP_START;
                end else begin
                    p_phase = PH_DONE;
                end
            end
            PH_EXP_START: begin
                if (is_sign) begin
                    p_exp_neg = (ch == CH_MINUS);
                    p_phase   = PH_EXP_DIGITS;
                end else if (is_digit) begin
                    p_exp   = exp_over ? COUNT_MAX : exp_step[COUNT_WIDTH-1:0];
                    p_sat   = sat_reg | exp_over;
                    p_phase = PH_EXP_DIGITS;
                end else begin
                    p_phase = PH_DONE;
                end
            end
            PH_EXP_DIGITS: begin
                if (is_digit) begin
                    p_exp = exp_over ? COUNT_MAX : exp_step[COUNT_WIDTH-1:0];
                    p_sat = sat_reg | exp_over;
                end else begin
                    p_phase = PH_DONE;
                end
            end
            default: begin
                p_phase = PH_DONE;
            end
        endcase
    end

    // Counts never exceed 9999, so they fit the exponent field as positives.
    assign exp_signed = (p_exp_neg ? -EXP_WIDTH'(p_exp) : EXP_WIDTH'(p_exp))
                      - EXP_WIDTH'(p_frac);

    always_comb begin
        phase_next    = phase_reg;
        neg_next      = neg_reg;
        acc_next      = acc_reg;
        frac_next     = frac_reg;
        exp_neg_next  = exp_neg_reg;
        exp_next      = exp_reg;
        sat_next      = sat_reg;
        in_valid_next = in_valid_reg;
        m_valid_next  = m_valid_reg;

        m_data_next.is_negative      = p_neg;
        m_data_next.mantissa         = 64'(p_acc);
        m_data_next.decimal_exponent = exp_signed;
        m_data_next.overflowed       = p_sat;

        if (fire) begin
            in_valid_next = 1'b0;
            if (in_data_reg.end_of_text) begin
                // The string is finished: start over for the next one.
                phase_next   = PH_SKIP;
                neg_next     = 1'b0;
                acc_next     = '0;
                frac_next    = '0;
                exp_neg_next = 1'b0;
                exp_next     = '0;
                sat_next     = 1'b0;
            end else begin
                phase_next   = p_phase;
                neg_next     = p_neg;
                acc_next     = p_acc;
                frac_next    = p_frac;
                exp_neg_next = p_exp_neg;
                exp_next     = p_exp;
                sat_next     = p_sat;
            end
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (fire && in_data_reg.end_of_text) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            phase_reg    <= PH_SKIP;
            neg_reg      <= 1'b0;
            acc_reg      <= '0;
            frac_reg     <= '0;
            exp_neg_reg  <= 1'b0;
            exp_reg      <= '0;
            sat_reg      <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            phase_reg    <= phase_next;
            neg_reg      <= neg_next;
            acc_reg      <= acc_next;
            frac_reg     <= frac_next;
            exp_neg_reg  <= exp_neg_next;
            exp_reg      <= exp_next;
            sat_reg      <= sat_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (fire && in_data_reg.end_of_text) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[dv/decimal_parse_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Decimal parse checker
// Watches both channels of the text parser. It tracks the parse of each
// accepted character, queues the expected number for every character marked
// end_of_text, and compares each delivered number field by field.
// ----------------------------------------------------------------------------
module decimal_parse_checker
    import dstp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  dstp_in_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  dstp_out_t m_data,
    output int        error_count,
    output int        pending_results
);

    // Tracked parse state.
    phase_t                  parse_state;
    logic                    minus_seen;
    logic [63:0]             mantissa_acc;
    logic [COUNT_WIDTH-1:0]  frac_digits;
    logic                    exp_minus;
    logic [COUNT_WIDTH-1:0]  exp_acc;
    logic                    clipped;

    dstp_out_t expected_numbers[$];

    task automatic clear_parse();
        parse_state  = PH_SKIP;
        minus_seen   = 1'b0;
        mantissa_acc = '0;
        frac_digits  = '0;
        exp_minus    = 1'b0;
        exp_acc      = '0;
        clipped      = 1'b0;
    endtask

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    task automatic push_mantissa_digit(input logic [7:0] c);
        logic [63:0] d;
        d = 64'(c - CH_ZERO);
        if (mantissa_acc > (MANT_MAX - d) / 10) begin
            mantissa_acc = MANT_MAX;
            clipped      = 1'b1;
        end else begin
            mantissa_acc = mantissa_acc * 10 + d;
        end
    endtask

    task automatic push_exponent_digit(input logic [7:0] c);
        logic [31:0] v;
        v = 32'(exp_acc) * 10 + 32'(c - CH_ZERO);
        if (v > 32'(COUNT_MAX)) begin
            v       = 32'(COUNT_MAX);
            clipped = 1'b1;
        end
        exp_acc = COUNT_WIDTH'(v);
    endtask

    task automatic count_fraction_digit();
        if (frac_digits >= COUNT_MAX) begin
            frac_digits = COUNT_MAX;
            clipped     = 1'b1;
        end else begin
            frac_digits = frac_digits + 1'b1;
        end
    endtask

    // Advances the parse by one character; on the last character of a text it
    // returns the finished number and starts over.
    task automatic parse_character(input dstp_in_t item, output bit done,
                                   output dstp_out_t number);
        logic [7:0] c;
        bit         exp_mark;
        bit         sign_char;
        int         exp_val;
        int         frac_val;
        c         = item.char_code;
        exp_mark  = (c == CH_LOW_E) || (c == CH_UP_E);
        sign_char = (c == CH_PLUS) || (c == CH_MINUS);
        case (parse_state)
            PH_SKIP: begin
                if (!is_blank(c)) begin
                    if (sign_char) begin
                        minus_seen  = (c == CH_MINUS);
                        parse_state = PH_INT;
                    end else if (is_digit(c)) begin
                        push_mantissa_digit(c);
                        parse_state = PH_INT;
                    end else if (c == CH_POINT) begin
                        parse_state = PH_FRAC;
                    end else if (exp_mark) begin
                        parse_state = PH_EXP_START;
                    end else begin
                        parse_state = PH_DONE;
                    end
                end
            end
            PH_INT: begin
                if (is_digit(c)) push_mantissa_digit(c);
                else if (c == CH_POINT) parse_state = PH_FRAC;
                else if (exp_mark) parse_state = PH_EXP_START;
                else parse_state = PH_DONE;
            end
            PH_FRAC: begin
                if (is_digit(c)) begin
                    push_mantissa_digit(c);
                    count_fraction_digit();
                end else if (exp_mark) begin
                    parse_state = PH_EXP_START;
                end else begin
                    parse_state = PH_DONE;
                end
            end
            PH_EXP_START: begin
                if (sign_char) begin
                    exp_minus   = (c == CH_MINUS);
                    parse_state = PH_EXP_DIGITS;
                end else if (is_digit(c)) begin
                    push_exponent_digit(c);
                    parse_state = PH_EXP_DIGITS;
                end else begin
                    parse_state = PH_DONE;
                end
            end
            PH_EXP_DIGITS: begin
                if (is_digit(c)) push_exponent_digit(c);
                else parse_state = PH_DONE;
            end
            default: parse_state = PH_DONE;
        endcase

        done   = item.end_of_text;
        number = '0;
        if (done) begin
            exp_val  = exp_acc;
            frac_val = frac_digits;
            exp_val  = (exp_minus ? -exp_val : exp_val) - frac_val;
            number.is_negative      = minus_seen;
            number.mantissa         = mantissa_acc;
            number.decimal_exponent = exp_val[EXP_WIDTH-1:0];
            number.overflowed       = clipped;
            clear_parse();
        end
    endtask

    task automatic note_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] seen);
        if (error_count < 10)
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h",
                     $realtime, field, want, seen);
        error_count++;
    endtask

    always @(posedge aclk) begin
        dstp_out_t want;
        dstp_out_t number;
        bit        done;
        if (!aresetn) begin
            clear_parse();
            expected_numbers.delete();
            error_count = 0;
        end else begin
            // Compare first: a delivered number always belongs to an older item.
            if (m_valid && m_ready) begin
                if (expected_numbers.size() == 0) begin
                    note_mismatch("unexpected number", '0, m_data.mantissa);
                end else begin
                    want = expected_numbers.pop_front();
                    if (m_data.is_negative !== want.is_negative)
                        note_mismatch("is_negative", 64'(want.is_negative),
                                      64'(m_data.is_negative));
                    if (m_data.mantissa !== want.mantissa)
                        note_mismatch("mantissa", want.mantissa, m_data.mantissa);
                    if (m_data.decimal_exponent !== want.decimal_exponent)
                        note_mismatch("decimal_exponent", 64'(want.decimal_exponent),
                                      64'(m_data.decimal_exponent));
                    if (m_data.overflowed !== want.overflowed)
                        note_mismatch("overflowed", 64'(want.overflowed),
                                      64'(m_data.overflowed));
                end
            end
            if (s_valid && s_ready) begin
                parse_character(s_data, done, number);
                if (done) expected_numbers.push_back(number);
            end
        end
        pending_results = expected_numbers.size();
    end

endmodule

[dv/decimal_scientific_text_parser_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Decimal scientific text parser testbench
// Streams directed and random number texts, one character per item, into the
// parser with random idle cycles on both sides and one long output stall.
// A checker beside the block predicts and compares every parsed number.
// ----------------------------------------------------------------------------
module decimal_scientific_text_parser_unit_tb;
    import dstp_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_CHARS = 230;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    dstp_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    dstp_out_t m_data;

    int error_count;
    int pending_results;
    int stall_cycles = 0;
    bit quiet        = 1'b0;
    bit hold_request = 1'b0;

    decimal_scientific_text_parser_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    decimal_parse_checker checker_inst (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .error_count     (error_count),
        .pending_results (pending_results)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Receiver: random back-pressure, plus one long hold when requested.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_request = 1'b0;
            end else begin
                m_ready <= quiet || ($urandom_range(99) >= 15);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("decimal_scientific_text_parser_unit_tb: done, errors");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_char(input logic [7:0] c, input logic last);
        while (!quiet && $urandom_range(99) < 15) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{char_code: c, end_of_text: last};
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_text(input logic [7:0] text[$]);
        foreach (text[i]) send_char(text[i], i == text.size() - 1);
    endtask

    task automatic send_string(input string txt);
        logic [7:0] text[$];
        for (int i = 0; i < txt.len(); i++) text.push_back(txt[i]);
        send_text(text);
    endtask

    task automatic add_digits(ref logic [7:0] text[$], input int n);
        repeat (n) text.push_back(CH_ZERO + 8'($urandom_range(9)));
    endtask

    function automatic logic [7:0] random_sign();
        return $urandom_range(1) ? CH_MINUS : CH_PLUS;
    endfunction

    // Mostly well-formed numbers with random content; the rest is character
    // soup from the parser's alphabet or raw bytes.
    task automatic build_random_text(ref logic [7:0] text[$]);
        int kind;
        int pick;
        kind = $urandom_range(99);
        text.delete();
        if (kind < 60) begin
            repeat ($urandom_range(2))
                text.push_back($urandom_range(3) == 0 ? CH_SPACE
                                                      : CH_TAB + 8'($urandom_range(4)));
            if ($urandom_range(1)) text.push_back(random_sign());
            add_digits(text, $urandom_range(9) == 0 ? $urandom_range(17, 22)
                                                    : $urandom_range(6));
            if ($urandom_range(1)) begin
                text.push_back(CH_POINT);
                add_digits(text, $urandom_range(6));
            end
            if ($urandom_range(1)) begin
                text.push_back($urandom_range(1) ? CH_LOW_E : CH_UP_E);
                if ($urandom_range(1)) text.push_back(random_sign());
                add_digits(text, $urandom_range(7) == 0 ? $urandom_range(5, 6)
                                                        : $urandom_range(3));
            end
            if ($urandom_range(3) == 0) text.push_back(8'($urandom_range(255)));
        end else if (kind < 85) begin
            repeat ($urandom_range(1, 12)) begin
                pick = $urandom_range(9);
                case (pick)
                    0: text.push_back(CH_PLUS);
                    1: text.push_back(CH_MINUS);
                    2: text.push_back(CH_POINT);
                    3: text.push_back(CH_LOW_E);
                    4: text.push_back(CH_UP_E);
                    5: text.push_back(CH_SPACE);
                    6: text.push_back(8'($urandom_range(255)));
                    default: text.push_back(CH_ZERO + 8'($urandom_range(9)));
                endcase
            end
        end else begin
            repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(255)));
        end
        if (text.size() == 0) text.push_back(CH_ZERO + 8'($urandom_range(9)));
    endtask

    initial begin
        logic [7:0] text[$];
        int         sent_chars;
        int         sent_texts;

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed texts.
        send_string("0");
        send_string("   -123.456e+7");
        send_string("\011\012\013\014\015+9");
        send_string("9999999999999999999");
        send_string("99999999999999999990");
        send_string("18446744073709551616");
        send_string(".5");
        send_string("e5");
        send_string("E-");
        send_string("1e");
        send_string("1ex2");
        send_string("7E3");
        send_string("abc");
        send_string("-");
        send_string("+.e+");
        send_string("12.34.5");
        send_string("3.0e-12x9");
        send_string("1e99999");
        send_string("-1e-99999");
        send_string("\377\200z");

        // Random texts, with a quiet stretch and one long output hold.
        sent_chars = 0;
        sent_texts = 0;
        while (sent_chars < RANDOM_CHARS || sent_texts < 30) begin
            quiet = (sent_texts >= 10 && sent_texts < 20);
            if (sent_texts == 25) begin
                hold_request = 1'b1;
                repeat (30) send_char(CH_ZERO + 8'($urandom_range(9)), 1'b1);
            end
            build_random_text(text);
            send_text(text);
            sent_chars += text.size();
            sent_texts++;
        end
        quiet = 1'b0;
        s_valid <= 1'b0;

        while (pending_results != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (error_count == 0) begin
            $display("decimal_scientific_text_parser_unit_tb: done, clean");
        end else begin
            $display("decimal_scientific_text_parser_unit_tb: done, errors");
        end
        $finish;
    end

endmodule

[filelist.f]
design/dstp_pkg.sv
design/decimal_scientific_text_parser_unit.sv
dv/decimal_parse_checker.sv
dv/decimal_scientific_text_parser_unit_tb.sv
